@@ rtl/aes128_pkg.sv @@
// shared types, s-box and round helpers for the aes-128 encrypt pipeline
package aes128_pkg;

  localparam int NumRounds = 10;

  localparam logic [7:0] RconInit = 8'h01;

  localparam logic [3:0] RegKeyHigh = 4'h0;
  localparam logic [3:0] RegKeyLow  = 4'h8;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   valid;
    block_t state;
  } stage_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
    8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
    8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
    8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
    8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
    8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
    8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
    8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
    8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
    8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
    8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
    8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits 127-8i
  function automatic logic [7:0] get_byte(input block_t s, input int i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(4*c + r) -: 8] = Sbox[get_byte(s, 4*((c + r) % 4) + r)];
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

@@ rtl/block_cipher_128_encrypt.sv @@
// top level of the pipelined aes-128 encryptor
// usage:
//   key: write key_high at address 0 and key_low at address 8 through the
//   apb port while the pipeline is empty; round key g passes through g
//   schedule registers, as many as a beat passes before round g, so a
//   beat may follow the last key write in the next cycle
//   input: s_tvalid/s_tready beat carries the plaintext
//   output: m_tvalid/m_tready beat carries the ciphertext
//   pipeline: the beat's edge loads the initial key add register, then one
//   register per round carries it to the output stage that drives m_tvalid;
//   throughput one beat per cycle unless stalled, from ten unrolled rounds
//   stall: the whole pipeline freezes when the output register is full and
//   not taken; s_tready is high whenever the output stage can move
//   reset: clears keys to zero and all valid bits
module block_cipher_128_encrypt (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // plain_high[63:0], plain_low[127:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // cipher_high[63:0], cipher_low[127:64]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int N = aes128_pkg::NumRounds;

  aes128_pkg::block_t round_keys [N + 1];
  aes128_pkg::stage_t stages [N + 1];
  logic enable;

  aes128_keys u_keys (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .round_keys
  );

  // global stall: move when the last stage is empty or being taken
  assign enable   = !stages[N].valid || m_tready;
  assign s_tready = enable;

  // initial add round key; byte 0 of the block sits in the top bits
  always_ff @(posedge clk) begin
    if (enable) stages[0].state <= {s_tdata[63:0], s_tdata[127:64]} ^ round_keys[0];
    if (rst)         stages[0].valid <= 1'b0;
    else if (enable) stages[0].valid <= s_tvalid;
  end

  for (genvar g = 1; g <= N; g++) begin : g_round
    aes128_round u_round (
      .clk, .rst, .enable,
      .last      (g == N),
      .in_stage  (stages[g-1]),
      .round_key (round_keys[g]),
      .out_stage (stages[g])
    );
  end

  assign m_tvalid = stages[N].valid;
  assign m_tdata  = {stages[N].state[63:0], stages[N].state[127:64]};

  // a stalled result holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");

  // input is refused exactly when the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow the stall");

  // a beat in the first stage reaches the second one when the pipe moves
  a_move: assert property (@(posedge clk) disable iff (rst)
    stages[0].valid && enable |=> stages[1].valid)
    else $error("beat lost between stages");

endmodule

@@ rtl/aes128_keys.sv @@
// key registers, apb port and registered round key expansion
module aes128_keys (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  output aes128_pkg::block_t     round_keys [aes128_pkg::NumRounds + 1]
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [7:0]  rcon [aes128_pkg::NumRounds];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        aes128_pkg::RegKeyHigh: key_high <= pwdata;
        aes128_pkg::RegKeyLow:  key_low  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      aes128_pkg::RegKeyHigh: prdata = key_high;
      aes128_pkg::RegKeyLow:  prdata = key_low;
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    rcon[0] = aes128_pkg::RconInit;
    for (int i = 1; i < aes128_pkg::NumRounds; i++)
      rcon[i] = aes128_pkg::xtime(rcon[i-1]);
  end

  // one key schedule step per register; round key g passes through g
  // registers, just as a beat passes g registers before it reaches round g
  assign round_keys[0] = {key_high, key_low};

  for (genvar g = 1; g <= aes128_pkg::NumRounds; g++) begin : g_key
    aes128_pkg::block_t rk;
    always_ff @(posedge clk) begin
      if (rst) rk <= '0;
      else     rk <= aes128_pkg::next_key(round_keys[g-1], rcon[g-1]);
    end
    assign round_keys[g] = rk;
  end

endmodule

@@ rtl/aes128_round.sv @@
// one cipher round stage with valid and stall handling
module aes128_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  logic                last,
  input  aes128_pkg::stage_t  in_stage,
  input  aes128_pkg::block_t  round_key,
  output aes128_pkg::stage_t  out_stage
);

  aes128_pkg::block_t shifted;
  aes128_pkg::block_t mixed;

  always_comb begin
    shifted = aes128_pkg::sub_shift(in_stage.state);
    mixed   = last ? shifted : aes128_pkg::mix_columns(shifted);
  end

  always_ff @(posedge clk) begin
    if (enable) out_stage.state <= mixed ^ round_key;
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (enable) begin
      out_stage.valid <= in_stage.valid;
    end
  end

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the aes-128 encrypt pipeline
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // address map of the key registers, taken from the package
  localparam logic [3:0] AddrKeyHigh = aes128_pkg::RegKeyHigh;
  localparam logic [3:0] AddrKeyLow  = aes128_pkg::RegKeyLow;
  localparam int IdleLimit = 5000;
  localparam int Latency   = 11;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // plain_high[63:0], plain_low[127:64]
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // cipher_high[63:0], cipher_low[127:64]
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  block_cipher_128_encrypt u_dut (.*);

  // ---------------------------------------------------------------------
  // aes-128 predictor, written byte-wise; s-box built from gf(2^8) math
  // ---------------------------------------------------------------------
  class cipher_scoreboard;
    logic [7:0]   sb [256];
    logic [63:0]  key_hi, key_lo;
    logic [127:0] cipher_q [$];
    int           errors;

    function new();
      logic [7:0] p, q, x;
      p = 8'h01;
      q = 8'h01;
      do begin
        p = p ^ gmul2(p);
        q = q ^ (q << 1);
        q = q ^ (q << 2);
        q = q ^ (q << 4);
        if (q[7]) q = q ^ 8'h09;
        x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
        sb[p] = x ^ 8'h63;
      end while (p != 8'h01);
      sb[0] = 8'h63;
      key_hi = '0;
      key_lo = '0;
      errors = 0;
    endfunction

    function logic [7:0] gmul2(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function logic [127:0] encrypt(logic [127:0] pt);
      logic [7:0] w [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] tw [4];
      logic [7:0] rc, a0, a1, a2, a3, al, tmp;
      logic [127:0] key, res;
      key = {key_hi, key_lo};
      for (int i = 0; i < 16; i++) begin
        w[i] = key[127 - 8*i -: 8];
        s[i] = pt[127 - 8*i -: 8];
      end
      rc = 8'h01;
      for (int i = 16; i < 176; i += 4) begin
        for (int j = 0; j < 4; j++) tw[j] = w[i - 4 + j];
        if (i % 16 == 0) begin
          tmp = tw[0];
          tw[0] = sb[tw[1]] ^ rc;
          tw[1] = sb[tw[2]];
          tw[2] = sb[tw[3]];
          tw[3] = sb[tmp];
          rc = gmul2(rc);
        end
        for (int j = 0; j < 4; j++) w[i + j] = w[i - 16 + j] ^ tw[j];
      end
      for (int i = 0; i < 16; i++) s[i] ^= w[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*c + r] = sb[s[4*((c + r) % 4) + r]];
        s = t;
        if (rnd < 10)
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c + 1]; a2 = s[4*c + 2]; a3 = s[4*c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            s[4*c]     = a0 ^ al ^ gmul2(a0 ^ a1);
            s[4*c + 1] = a1 ^ al ^ gmul2(a1 ^ a2);
            s[4*c + 2] = a2 ^ al ^ gmul2(a2 ^ a3);
            s[4*c + 3] = a3 ^ al ^ gmul2(a3 ^ a0);
          end
        for (int i = 0; i < 16; i++) s[i] ^= w[16*rnd + i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
    endfunction

    // note one accepted plaintext beat; plain_high sits in the low half
    function void note_plain(logic [127:0] pt);
      cipher_q.push_back(encrypt({pt[63:0], pt[127:64]}));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("error: %s got %h expected %h", what, got, want);
      errors++;
    endtask

    // compare one ciphertext beat against the oldest prediction
    task check_cipher(logic [127:0] ct);
      logic [127:0] want;
      if (cipher_q.size() == 0) begin
        report("unexpected cipher beat", ct[63:0], '0);
        return;
      end
      want = cipher_q.pop_front();
      if (ct[63:0] !== want[127:64]) report("cipher_high", ct[63:0], want[127:64]);
      if (ct[127:64] !== want[63:0]) report("cipher_low", ct[127:64], want[63:0]);
    endtask
  endclass

  cipher_scoreboard scb;
  int  idle_cycles;
  bit  hold_off;   // long receiver hold-off requested by the stimulus
  bit  stall_on;   // receiver random stalls enabled

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: plaintext beats go to the predictor, cipher beats to the check
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) scb.note_plain(s_tdata);
      if (m_tvalid && m_tready) scb.check_cipher(m_tdata);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: its own stall pattern, plus the long hold-off
  initial begin
    int phase;
    m_tready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) m_tready <= 1'b0;
      else if (!stall_on) m_tready <= 1'b1;
      else if ((phase / 16) % 3 == 2) m_tready <= 1'b1;  // stretch without stalls
      else m_tready <= ($urandom_range(0, 99) < 60);
    end
  end

  // apb write: setup then access
  task apb_write(logic [3:0] addr, logic [63:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrKeyHigh) scb.key_hi = data;
    else if (addr == AddrKeyLow) scb.key_lo = data;
  endtask

  // new key only with an empty pipeline, then let round keys settle
  task load_key(logic [63:0] hi, logic [63:0] lo);
    while (scb.cipher_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    apb_write(AddrKeyHigh, hi);
    apb_write(AddrKeyLow, lo);
    repeat (Latency) @(posedge clk);
  endtask

  // send one plaintext beat; valid stays up if the next call follows at once
  task send_plain(logic [127:0] pt);
    s_tvalid <= 1'b1;
    s_tdata  <= pt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task send_gap();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function logic [127:0] rand_plain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {rand64(), 64'd0};
      default: return {rand64(), rand64()};
    endcase
  endfunction

  // bursts of random length with random gaps
  task random_burst_run(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_plain(rand_plain());
      left -= burst;
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    scb = new();
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_off = 1'b0; stall_on = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset key of zero first, then the standard test key
    send_plain('0);
    send_plain('1);
    s_tvalid <= 1'b0;
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_plain(128'he0370734313198a2885a308d3243f6a8);
    send_plain(128'h8899aabbccddeeff0011223344556677);
    s_tvalid <= 1'b0;
    load_key('1, '1);
    send_plain('0);
    send_plain('1);
    send_plain(128'h80000000000000000000000000000001);
    s_tvalid <= 1'b0;
    // key change between steps: only key_low differs
    load_key('1, '0);
    send_plain('1);
    s_tvalid <= 1'b0;
    load_key('0, '0);
    send_plain(128'h0123456789abcdeffedcba9876543210);
    s_tvalid <= 1'b0;

    // random phases, each under its own key
    stall_on = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      load_key(rand64(), rand64());
      if (ph == 2) begin
        // long hold-off so the pipeline fills and stalls its input
        hold_off = 1'b1;
        fork
          begin
            repeat (200) @(posedge clk);
            hold_off = 1'b0;
          end
          random_burst_run(90);
        join
      end else begin
        random_burst_run(90);
      end
    end

    while (scb.cipher_q.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
    if (scb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

@@ block_cipher_128_encrypt.f @@
rtl/aes128_pkg.sv
rtl/aes128_keys.sv
rtl/aes128_round.sv
rtl/block_cipher_128_encrypt.sv
dv/tb.sv
